@@ design/pmfd_pkg.sv @@
// Shared constants, register indexes and the sine table generator for the mask pipeline.
package pmfd_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned DIST_W  = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned MASK_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DT_LAMBDA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_MODE  = 2'd2;

  localparam logic [CFG_W-1:0]  HALF_WIDTH_RST = 31'd65536;
  localparam logic [CFG_W-1:0]  DT_LAMBDA_RST  = 31'd65536;
  localparam logic [MASK_W-1:0] ONE_Q16        = 17'd65536;

  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [27:0] INV_TWO_PI_Q30 = 28'd170891318;

  // Eleven-term Taylor series of sin in Q2.30, truncating at each step.
  function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    a    = (HALF_PI_Q30 * 64'(k)) >> bits;
    a2   = (a * a) >> 30;
    term = a;
    sum  = a;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[31:0];
  endfunction

endpackage

@@ design/penalization_mask_from_distance.sv @@
// Throughput: one item per cycle; two 17-step restoring dividers, one bit per stage,
// set the depth, and every stage advances together unless the output is stalled.
// Reset: valid bits clear and the registers return to half width 1.0, dt*lambda 1.0,
// plain mask mode. Payload registers are not reset. The sine table is constant.
module penalization_mask_from_distance import pmfd_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DIST_W-1:0]    distance_i,
  input  logic                 last_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MASK_W-1:0]    mask_value_o,
  output logic                 last_out_o
);

  localparam int unsigned SINE_ENTRIES = (1 << SINE_TABLE_BITS) + 1;
  localparam int unsigned IDX_W        = SINE_TABLE_BITS + 1;
  localparam int unsigned POS_W        = 16 + SINE_TABLE_BITS;
  localparam int unsigned DIV_STEPS    = 17;
  localparam logic [IDX_W-1:0] SINE_LAST = IDX_W'(1 << SINE_TABLE_BITS);

  typedef logic [31:0] sine_tab_t [SINE_ENTRIES];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
      tab[k] = sine_entry(k, SINE_TABLE_BITS);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Configuration registers; write them only while the pipeline is empty (the block does not enforce this).
  logic [CFG_W-1:0] hw_q, dl_q;
  logic             semi_q;
  logic [CFG_W-1:0] hw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= HALF_WIDTH_RST;
      dl_q   <= DT_LAMBDA_RST;
      semi_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_WIDTH: hw_q   <= cfg_data_i;
        REG_DT_LAMBDA:  dl_q   <= cfg_data_i;
        REG_SEMI_MODE:  semi_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A zero half width behaves as the smallest step.
  assign hw = (hw_q == '0) ? CFG_W'(1) : hw_q;

  // Whole pipeline moves as one; hold everything while the output item waits.
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------- input stage
  // Take the magnitude, classify against the band and form the first
  // dividend of m = round(|d| * 2^16 / h).
  logic        in_neg;
  logic [31:0] in_mag;
  logic [47:0] in_num;

  assign in_neg = distance_i[31];
  assign in_mag = in_neg ? (~distance_i + 32'd1) : distance_i;
  assign in_num = {in_mag, 16'd0} + 48'(hw >> 1);

  logic              a_v_q    [DIV_STEPS+1];
  logic              a_last_q [DIV_STEPS+1];
  logic              a_neg_q  [DIV_STEPS+1];
  logic              a_band_q [DIV_STEPS+1];
  logic [CFG_W-1:0]  a_rem_q  [DIV_STEPS+1];
  logic [16:0]       a_low_q  [DIV_STEPS+1];
  logic [16:0]       a_quo_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q[0] <= 1'b0;
    end else if (adv) begin
      a_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_last_q[0] <= last_item_i;
      a_neg_q[0]  <= in_neg;
      a_band_q[0] <= in_mag <= {1'b0, hw};
      a_rem_q[0]  <= in_num[47:17];
      a_low_q[0]  <= in_num[16:0];
      a_quo_q[0]  <= '0;
    end
  end

  // -------------------------------------------------------- band divider
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_m
    logic [CFG_W:0] t;
    logic           ge;
    assign t  = {a_rem_q[k], a_low_q[k][16]};
    assign ge = t >= {1'b0, hw};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        a_v_q[k+1] <= a_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_last_q[k+1] <= a_last_q[k];
        a_neg_q[k+1]  <= a_neg_q[k];
        a_band_q[k+1] <= a_band_q[k];
        a_rem_q[k+1]  <= ge ? CFG_W'(t - {1'b0, hw}) : CFG_W'(t);
        a_low_q[k+1]  <= {a_low_q[k][15:0], 1'b0};
        a_quo_q[k+1]  <= {a_quo_q[k][15:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- fold
  // Fold the half turn onto a quarter and split into table index and fraction.
  logic [16:0]      m_cl;
  logic [15:0]      fold_q16;
  logic [POS_W-1:0] fold_pos;

  assign m_cl     = (a_quo_q[DIV_STEPS] > ONE_Q16) ? ONE_Q16 : a_quo_q[DIV_STEPS];
  assign fold_q16 = (m_cl <= 17'd32768) ? m_cl[15:0] : 16'(ONE_Q16 - m_cl);
  assign fold_pos = POS_W'(fold_q16) << SINE_TABLE_BITS;

  logic             f_v_q, f_last_q, f_neg_q, f_band_q;
  logic [16:0]      f_m_q;
  logic [IDX_W-1:0] f_idx_q;
  logic [14:0]      f_frac_q;

  // ---------------------------------------------------------------- table read
  logic             r_v_q, r_last_q, r_neg_q, r_band_q;
  logic [16:0]      r_m_q;
  logic [14:0]      r_frac_q;
  logic [31:0]      r_lo_q, r_hi_q;

  // ---------------------------------------------------------------- interpolate
  logic [31:0]      ip_diff;
  logic [46:0]      ip_prod;
  logic             i_v_q, i_last_q, i_neg_q, i_band_q;
  logic [16:0]      i_m_q;
  logic [31:0]      i_s_q;

  assign ip_diff = r_hi_q - r_lo_q;
  assign ip_prod = 47'(ip_diff) * 47'(r_frac_q);

  // ---------------------------------------------------------------- scale by 1/(2 pi)
  logic [59:0]      p_prod;
  logic             p_v_q, p_last_q, p_neg_q, p_band_q;
  logic [16:0]      p_m_q;
  logic [29:0]      p_sub_q;

  assign p_prod = 60'(i_s_q) * 60'(INV_TWO_PI_Q30);

  // ---------------------------------------------------------------- plain mask
  logic [29:0]      c_c30, c_dif;
  logic [30:0]      c_rnd;
  logic [16:0]      c_c, c_chi;
  logic             c_v_q, c_last_q, c_need_q;
  logic [16:0]      c_chi_q;

  assign c_c30 = 30'(1 << 29) - {p_m_q, 13'd0};
  assign c_dif = (c_c30 > p_sub_q) ? (c_c30 - p_sub_q) : '0;
  assign c_rnd = (31'(c_dif) + 31'(1 << 13)) >> 14;
  assign c_c   = (c_rnd > 31'(ONE_Q16)) ? ONE_Q16 : c_rnd[16:0];
  always_comb begin
    if (p_band_q) begin
      c_chi = p_neg_q ? (ONE_Q16 - c_c) : c_c;
    end else begin
      c_chi = p_neg_q ? ONE_Q16 : '0;
    end
  end

  // ---------------------------------------------------------------- denominator
  logic             d_v_q, d_last_q, d_need_q;
  logic [16:0]      d_chi_q;
  logic [47:0]      d_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
      r_v_q <= 1'b0;
      i_v_q <= 1'b0;
      p_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (adv) begin
      f_v_q <= a_v_q[DIV_STEPS];
      r_v_q <= f_v_q;
      i_v_q <= r_v_q;
      p_v_q <= i_v_q;
      c_v_q <= p_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_last_q <= a_last_q[DIV_STEPS];
      f_neg_q  <= a_neg_q[DIV_STEPS];
      f_band_q <= a_band_q[DIV_STEPS];
      f_m_q    <= m_cl;
      f_idx_q  <= fold_pos[POS_W-1:15];
      f_frac_q <= fold_pos[14:0];

      r_last_q <= f_last_q;
      r_neg_q  <= f_neg_q;
      r_band_q <= f_band_q;
      r_m_q    <= f_m_q;
      r_frac_q <= f_frac_q;
      r_lo_q   <= SINE_TAB[f_idx_q];
      r_hi_q   <= (f_idx_q == SINE_LAST) ? SINE_TAB[f_idx_q] : SINE_TAB[f_idx_q + 1'b1];

      i_last_q <= r_last_q;
      i_neg_q  <= r_neg_q;
      i_band_q <= r_band_q;
      i_m_q    <= r_m_q;
      i_s_q    <= (r_hi_q < r_lo_q) ? r_lo_q : (r_lo_q + 32'(ip_prod >> 15));

      p_last_q <= i_last_q;
      p_neg_q  <= i_neg_q;
      p_band_q <= i_band_q;
      p_m_q    <= i_m_q;
      p_sub_q  <= p_prod[59:30];

      c_last_q <= p_last_q;
      c_chi_q  <= c_chi;
      c_need_q <= semi_q && (c_chi < ONE_Q16);

      d_last_q <= c_last_q;
      d_chi_q  <= c_chi_q;
      d_need_q <= c_need_q;
      d_den_q  <= 48'(dl_q) * 48'(ONE_Q16 - c_chi_q);
    end
  end

  // ------------------------------------------------ semi-implicit divider
  // v = chi * 2^32 / den; a quotient of 2^17 or more, or a zero den, saturates.
  logic [31:0] e_r0;
  assign e_r0 = {d_chi_q[16:0], 15'd0};

  logic        b_v_q    [DIV_STEPS+1];
  logic        b_last_q [DIV_STEPS+1];
  logic        b_need_q [DIV_STEPS+1];
  logic        b_sat_q  [DIV_STEPS+1];
  logic [16:0] b_chi_q  [DIV_STEPS+1];
  logic [47:0] b_den_q  [DIV_STEPS+1];
  logic [47:0] b_rem_q  [DIV_STEPS+1];
  logic [16:0] b_quo_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q[0] <= 1'b0;
    end else if (adv) begin
      b_v_q[0] <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_last_q[0] <= d_last_q;
      b_need_q[0] <= d_need_q;
      b_chi_q[0]  <= d_chi_q;
      b_den_q[0]  <= d_den_q;
      b_sat_q[0]  <= (d_den_q == '0) || (48'(e_r0) >= d_den_q);
      b_rem_q[0]  <= 48'(e_r0);
      b_quo_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_v
    logic [48:0] t;
    logic        ge;
    assign t  = {b_rem_q[k], 1'b0};
    assign ge = t >= {1'b0, b_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        b_v_q[k+1] <= b_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_last_q[k+1] <= b_last_q[k];
        b_need_q[k+1] <= b_need_q[k];
        b_sat_q[k+1]  <= b_sat_q[k];
        b_chi_q[k+1]  <= b_chi_q[k];
        b_den_q[k+1]  <= b_den_q[k];
        b_rem_q[k+1]  <= ge ? 48'(t - {1'b0, b_den_q[k]}) : 48'(t);
        b_quo_q[k+1]  <= {b_quo_q[k][15:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [16:0] o_mask_d, o_mask_q;
  logic        o_last_q;

  always_comb begin
    if (!b_need_q[DIV_STEPS]) begin
      o_mask_d = b_chi_q[DIV_STEPS];
    end else if (b_sat_q[DIV_STEPS] || (b_quo_q[DIV_STEPS] > ONE_Q16)) begin
      o_mask_d = ONE_Q16;
    end else begin
      o_mask_d = b_quo_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_mask_q <= o_mask_d;
      o_last_q <= b_last_q[DIV_STEPS];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mask_value_o = o_mask_q;
  assign last_out_o   = o_last_q;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the penalization mask pipeline.
module testbench;
  import pmfd_pkg::*;

  localparam int unsigned TBL_BITS  = SINE_TABLE_BITS_DEF;
  localparam int unsigned TBL_N     = (1 << TBL_BITS) + 1;
  localparam int unsigned LATENCY   = 43;
  localparam int unsigned MAX_CYCLES = 400000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last_item;
  } dist_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask_value;
    logic              last_out;
  } mask_item_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]  data;
    dist_item_t        item;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [DIST_W-1:0]    distance_i = '0;
  logic                 last_item_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [MASK_W-1:0]    mask_value_o;
  logic                 last_out_o;

  penalization_mask_from_distance i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: own copy of the registers and of the quarter-wave table.
  logic [31:0] sine_tbl [TBL_N];
  logic [30:0] band_half;
  logic [30:0] dt_lambda;
  logic        semi_mode;

  step_t      pending_q [$];
  mask_item_t expected_masks [$];

  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 68;
  bit          stim_done = 1'b0;
  bit          in_taken = 1'b0;

  // Eleven-term Taylor sine in Q2.30 with truncating steps.
  function automatic logic [31:0] taylor_sine(input logic [63:0] ang);
    logic [63:0] a2, term, sum;
    a2 = (ang * ang) >> 30;
    term = ang;
    sum = ang;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[31:0];
  endfunction

  function automatic logic [63:0] interp_sine(input logic [31:0] m);
    logic [31:0] q, idx;
    logic [63:0] pos, frac, lo, hi;
    q = (m <= 32768) ? m : (32'd65536 - m);
    pos = 64'(q) << TBL_BITS;
    idx = 32'(pos >> 15);
    frac = pos & 64'h7FFF;
    if (idx >= TBL_N - 1) return 64'(sine_tbl[TBL_N-1]);
    lo = 64'(sine_tbl[idx]);
    hi = 64'(sine_tbl[idx+1]);
    if (hi < lo) return lo;
    return lo + (((hi - lo) * frac) >> 15);
  endfunction

  function automatic logic [MASK_W-1:0] mask_of_distance(input logic [31:0] raw);
    logic        neg;
    logic [63:0] mag, h, s, c30, sub, c, den, v;
    logic [31:0] m, chi;
    neg = raw[31];
    mag = neg ? 64'(32'(~raw + 32'd1)) : 64'(raw);
    if (raw == 32'h8000_0000) mag = 64'h8000_0000;
    h = (band_half != 0) ? 64'(band_half) : 64'd1;
    if (!neg && mag > h) begin
      chi = 0;
    end else if (neg && mag > h) begin
      chi = 65536;
    end else begin
      m = 32'(((mag << 16) + (h >> 1)) / h);
      if (m > 65536) m = 65536;
      s = interp_sine(m);
      c30 = (64'd1 << 29) - (64'(m) << 13);
      sub = (s * 64'(INV_TWO_PI_Q30)) >> 30;
      c30 = (c30 > sub) ? c30 - sub : 64'd0;
      c = (c30 + (64'd1 << 13)) >> 14;
      if (c > 65536) c = 65536;
      chi = neg ? 32'(65536 - c) : 32'(c);
    end
    if (semi_mode && chi < 65536) begin
      den = 64'(dt_lambda) * 64'(65536 - chi);
      if (den == 0) begin
        chi = 65536;
      end else begin
        v = (64'(chi) << 32) / den;
        chi = (v > 65536) ? 32'd65536 : 32'(v);
      end
    end
    return chi[MASK_W-1:0];
  endfunction

  function automatic void queue_item(input logic [31:0] d, input logic lst);
    step_t s;
    s = '0;
    s.item.distance = d;
    s.item.last_item = lst;
    pending_q.push_back(s);
  endfunction

  function automatic void queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = val;
    pending_q.push_back(s);
  endfunction

  // Random distance, mostly inside or near the band so the sine path is exercised.
  function automatic logic [31:0] pick_distance(input logic [30:0] hw);
    logic [31:0] span, d;
    span = (hw == 0) ? 32'd1 : 32'(hw);
    case ($urandom_range(0, 9))
      0: d = $urandom;
      1: d = span + 32'($urandom_range(0, 3)) - 32'd1;
      2: d = -(span + 32'($urandom_range(0, 3)) - 32'd1);
      default: begin
        d = (span > 32'h4000_0000) ? $urandom : 32'($urandom) % (32'd2 * span + 32'd1);
        d = d - span;
      end
    endcase
    return d;
  endfunction

  // Driver: advance the queue at the falling edge; hold the payload until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
      end else if (in_valid_i && !in_taken) begin
        // hold
      end else if (pending_q.size() != 0 && pending_q[0].is_cfg) begin
        // write registers only once the pipeline has drained
        if (!in_valid_i && expected_masks.size() == 0 && !out_valid_o) begin
          repeat (LATENCY + 4) @(negedge clk_i);
          cfg_we_i <= 1'b1;
          cfg_idx_i <= pending_q[0].idx;
          cfg_data_i <= pending_q[0].data;
          case (pending_q[0].idx)
            REG_HALF_WIDTH: band_half = pending_q[0].data;
            REG_DT_LAMBDA:  dt_lambda = pending_q[0].data;
            default:        semi_mode = pending_q[0].data[0];
          endcase
          void'(pending_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        distance_i <= pending_q[0].item.distance;
        last_item_i <= pending_q[0].item.last_item;
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Record expectations at acceptance, using the registers in force for this item.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_masks.push_back('{mask_value: mask_of_distance(distance_i),
                                 last_out: last_item_i});
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    mask_item_t exp_m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result mask=%0d", mask_value_o);
      end else begin
        exp_m = expected_masks.pop_front();
        if (mask_value_o !== exp_m.mask_value || last_out_o !== exp_m.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mask=%0d last=%0b, got mask=%0d last=%0b",
                     exp_m.mask_value, exp_m.last_out, mask_value_o, last_out_o);
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [30:0] hw;
    for (int k = 0; k < TBL_N; k++)
      sine_tbl[k] = taylor_sine((64'(HALF_PI_Q30) * 64'(k)) >> TBL_BITS);
    band_half = HALF_WIDTH_RST;
    dt_lambda = DT_LAMBDA_RST;
    semi_mode = 1'b0;

    // Directed: extremes, band edges, centre, far outside, both last marks.
    queue_item(32'd0, 1'b0);
    queue_item(32'd65536, 1'b1);
    queue_item(-32'd65536, 1'b0);
    queue_item(32'd65537, 1'b0);
    queue_item(-32'd65537, 1'b1);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b1);
    queue_item(32'd32768, 1'b0);
    queue_item(-32'd32768, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b1);
    // semi-implicit with unit dt*lambda, then zero dt*lambda saturation
    queue_cfg(REG_SEMI_MODE, 31'd1);
    queue_item(32'd0, 1'b0);
    queue_item(32'd65536, 1'b0);
    queue_item(32'd70000, 1'b1);
    queue_item(-32'd20000, 1'b0);
    queue_cfg(REG_DT_LAMBDA, 31'd0);
    queue_item(32'd100000, 1'b0);
    queue_item(32'd1000, 1'b1);
    // zero half width is taken as one
    queue_cfg(REG_HALF_WIDTH, 31'd0);
    queue_item(32'd0, 1'b0);
    queue_item(32'd1, 1'b0);
    queue_item(-32'd1, 1'b1);
    queue_item(32'd2, 1'b0);

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: hw = 31'd1;
        1: hw = 31'h7FFF_FFFF;
        2: hw = 31'd65536;
        default: hw = 31'($urandom_range(1, 32'h00FF_FFFF));
      endcase
      queue_cfg(REG_HALF_WIDTH, hw);
      queue_cfg(REG_DT_LAMBDA, (ph == 3) ? 31'h7FFF_FFFF :
                               (ph == 4) ? 31'd1 : 31'($urandom_range(0, 32'h0004_0000)));
      queue_cfg(REG_SEMI_MODE, 31'(ph % 2));
      for (int n = 0; n < 150; n++)
        queue_item(pick_distance(hw), 1'($urandom_range(0, 1)));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idling profile switches by how much stimulus is left.
    wait (pending_q.size() < 1100);
    send_idle_pct = 68;
    recv_idle_pct = 24;
    wait (pending_q.size() < 550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_q.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i);
    wait (expected_masks.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_masks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
